// ----- src/satlb_pkg.sv -----
`timescale 1ns / 1ps

package satlb_pkg;

    // Field widths fixed by the request format
    localparam int unsigned PAGE_W  = 52;
    localparam int unsigned SPACE_W = 16;

    // Request commands
    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_FILL  = 1'b1;

    // One translation entry
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [SPACE_W-1:0] space;
        logic [PAGE_W-1:0]  phys;
    } t_entry;

endpackage

// ----- src/set_assoc_tlb_lru.sv -----
`timescale 1ns / 1ps

// Set-associative translation buffer with LRU replacement.
// Input channel: i_in_valid / o_in_stall carry one request (probe or fill)
// with i_cmd, i_space_id, i_virt_page and i_fill_phys_page. The set is the
// low bits of the virtual page.
// Output channel: o_out_valid / i_out_stall return one result per request,
// o_hit and o_phys_page (zero on a miss and on every fill).
// Path: a taken request goes from the compare stage registers to the result
// register. Throughput: one request per cycle while i_out_stall does not
// hold a full result register. The set row is read from memory in the accept
// cycle and written back on a fill or a hit as the request leaves the compare
// stage; a row written while the next request reads the same set is forwarded.
// Reset: all valid bits clear at once and the output register empties; no
// clearing pass runs, so requests are taken in the first cycle after reset.
// Stall: the result register holds while i_out_stall is high; one more
// request may wait in the compare stage, after which o_in_stall rises.
module set_assoc_tlb_lru #(
    parameter int unsigned SETS = 32,
    parameter int unsigned WAYS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [satlb_pkg::SPACE_W-1:0] i_space_id,
    input  logic [satlb_pkg::PAGE_W-1:0]  i_virt_page,
    input  logic [satlb_pkg::PAGE_W-1:0]  i_fill_phys_page,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic [satlb_pkg::PAGE_W-1:0]  o_phys_page
);

    localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned RW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        satlb_pkg::t_entry [WAYS-1:0] ent;
        logic [WAYS-1:0][RW-1:0]     rank;
    } t_row;

    // Handshake
    logic in_acc;
    logic adv1;
    logic [SW-1:0] in_set;

    // Compare stage registers
    logic                          r_s1_vld;
    logic                          r_cmd;
    logic [satlb_pkg::SPACE_W-1:0] r_space;
    logic [satlb_pkg::PAGE_W-1:0]  r_page;
    logic [satlb_pkg::PAGE_W-1:0]  r_phys;
    logic [SW-1:0]                 r_set;

    // Row memory, read data and forward path
    t_row r_mem [SETS];
    t_row r_mem_q;
    t_row r_fwd_row;
    logic r_fwd;

    // Valid bits per way
    logic [WAYS-1:0] r_valid [SETS];

    // Result register
    logic                         r_out_vld;
    logic                         r_hit;
    logic [satlb_pkg::PAGE_W-1:0] r_out_phys;

    // Compare stage logic
    t_row                    row;
    t_row                    n_row;
    logic [WAYS-1:0]         vbits;
    logic [WAYS-1:0][RW-1:0] rank_eff;
    logic [WAYS-1:0]         match;
    logic                    any_match;
    logic [WW-1:0]           hit_way;
    logic                    any_free;
    logic [WW-1:0]           free_way;
    logic [WW-1:0]           lru_way;
    logic [WW-1:0]           victim;
    logic [WW-1:0]           touch_way;
    logic [RW-1:0]           old_rank;
    logic                    is_fill;
    logic                    n_hit;
    logic                    row_we;
    logic [satlb_pkg::PAGE_W-1:0] n_out_phys;

    assign adv1       = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !adv1;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_set     = (SETS > 1) ? i_virt_page[SW-1:0] : '0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (adv1) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_cmd;
            r_space <= i_space_id;
            r_page  <= i_virt_page;
            r_phys  <= i_fill_phys_page;
            r_set   <= in_set;
        end
    end

    // Row memory: write back on leave, read on accept
    always_ff @(posedge i_clk) begin
        if (adv1 && row_we) begin
            r_mem[r_set] <= n_row;
        end
        if (in_acc) begin
            r_mem_q <= r_mem[in_set];
        end
    end

    // Forward a row written in the same cycle that the next request reads it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_acc) begin
            r_fwd <= adv1 && row_we && (in_set == r_set);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_row <= n_row;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else if (adv1 && is_fill) begin
            r_valid[r_set][victim] <= 1'b1;
        end
    end

    // Current row and ranks; a set with no valid way still has reset ranks
    always_comb begin
        row     = r_fwd ? r_fwd_row : r_mem_q;
        vbits   = r_valid[r_set];
        is_fill = (r_cmd == satlb_pkg::CMD_FILL);
        for (int w = 0; w < WAYS; w++) begin
            rank_eff[w] = (vbits == '0) ? RW'(w) : row.rank[w];
            match[w]    = vbits[w] && (row.ent[w].page == r_page)
                          && (row.ent[w].space == r_space);
        end
    end

    // Lowest matching way, lowest free way, least recent way
    always_comb begin
        any_match = |match;
        any_free  = ~&vbits;
        hit_way   = '0;
        free_way  = '0;
        lru_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WW'(w);
            end
            if (!vbits[w]) begin
                free_way = WW'(w);
            end
            if (rank_eff[w] == RW'(WAYS - 1)) begin
                lru_way = WW'(w);
            end
        end
        victim = any_free ? free_way : lru_way;
    end

    // Next row: fill writes the victim, both make the touched way most recent
    always_comb begin
        n_hit      = !is_fill && any_match;
        row_we     = is_fill || any_match;
        touch_way  = is_fill ? victim : hit_way;
        old_rank   = rank_eff[touch_way];
        n_out_phys = n_hit ? row.ent[hit_way].phys : '0;
        n_row      = row;
        for (int w = 0; w < WAYS; w++) begin
            if (WW'(w) == touch_way) begin
                n_row.rank[w] = '0;
            end else if (rank_eff[w] < old_rank) begin
                n_row.rank[w] = rank_eff[w] + RW'(1);
            end else begin
                n_row.rank[w] = rank_eff[w];
            end
        end
        if (is_fill) begin
            n_row.ent[victim].page  = r_page;
            n_row.ent[victim].space = r_space;
            n_row.ent[victim].phys  = r_phys;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv1) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_hit      <= n_hit;
            r_out_phys <= n_out_phys;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_hit       = r_hit;
    assign o_phys_page = r_out_phys;

    // Assertions
    logic [WAYS-1:0] mru_vec;
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            mru_vec[w] = (n_row.rank[w] == '0);
        end
    end

    a_mru_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && row_we) |-> $onehot(mru_vec))
        else $error("written row does not have exactly one most recent way");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_phys_page == '0))
        else $error("miss result carries a nonzero physical page");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a full pipeline");

    a_fill_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && is_fill) |=> (r_out_vld && !r_hit))
        else $error("fill request produced a hit");

    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && is_fill) |=> r_valid[$past(r_set)][$past(victim)])
        else $error("filled way not marked valid");

endmodule

// ----- test/set_assoc_tlb_lru_chk.sv -----
`timescale 1ns / 1ps

// Watches both channels of the translation buffer, keeps a shadow copy of
// every set and checks each result against the oldest predicted one.
module set_assoc_tlb_lru_chk #(
    parameter int unsigned SETS = 32,
    parameter int unsigned WAYS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_cmd,
    input  logic [satlb_pkg::SPACE_W-1:0] i_space_id,
    input  logic [satlb_pkg::PAGE_W-1:0]  i_virt_page,
    input  logic [satlb_pkg::PAGE_W-1:0]  i_fill_phys_page,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_hit,
    input  logic [satlb_pkg::PAGE_W-1:0]  i_phys_page,
    output int                            o_errors,
    output int                            o_outstanding,
    output int                            o_fills,
    output int                            o_hits,
    output int                            o_misses
);

    typedef struct packed {
        logic                         hit;
        logic [satlb_pkg::PAGE_W-1:0] phys;
    } t_translation;

    // Shadow copy of the buffer
    logic              shadow_valid [SETS][WAYS];
    satlb_pkg::t_entry shadow_entry [SETS][WAYS];
    int unsigned       shadow_rank  [SETS][WAYS];

    t_translation expected_translations[$];

    // Way becomes rank 0; every way that was more recent ages by one
    function automatic void promote_way(int unsigned set_idx, int unsigned way);
        int unsigned old_rank;
        old_rank = shadow_rank[set_idx][way];
        for (int w = 0; w < WAYS; w++) begin
            if (shadow_rank[set_idx][w] < old_rank)
                shadow_rank[set_idx][w]++;
        end
        shadow_rank[set_idx][way] = 0;
    endfunction

    // Applies one request to the shadow copy and returns its result
    function automatic t_translation translate_request(
        logic                          cmd,
        logic [satlb_pkg::SPACE_W-1:0] space,
        logic [satlb_pkg::PAGE_W-1:0]  page,
        logic [satlb_pkg::PAGE_W-1:0]  phys
    );
        int unsigned  set_idx;
        int unsigned  victim;
        bit           free_found;
        t_translation res;
        set_idx    = int'(page % SETS);
        res        = '0;
        victim     = 0;
        free_found = 1'b0;
        if (cmd == satlb_pkg::CMD_PROBE) begin
            // lowest matching way wins
            for (int w = 0; w < WAYS; w++) begin
                if (!res.hit && shadow_valid[set_idx][w] &&
                    shadow_entry[set_idx][w].page == page &&
                    shadow_entry[set_idx][w].space == space) begin
                    res.hit  = 1'b1;
                    res.phys = shadow_entry[set_idx][w].phys;
                    promote_way(set_idx, w);
                end
            end
        end else begin
            // first free way, else the least recent one
            for (int w = 0; w < WAYS; w++) begin
                if (!free_found && !shadow_valid[set_idx][w]) begin
                    victim     = w;
                    free_found = 1'b1;
                end
            end
            if (!free_found) begin
                for (int w = 1; w < WAYS; w++) begin
                    if (shadow_rank[set_idx][w] > shadow_rank[set_idx][victim])
                        victim = w;
                end
            end
            shadow_valid[set_idx][victim]       = 1'b1;
            shadow_entry[set_idx][victim].page  = page;
            shadow_entry[set_idx][victim].space = space;
            shadow_entry[set_idx][victim].phys  = phys;
            promote_way(set_idx, victim);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("ERROR @%0t: %s: expected %h, got %h", $time, what, want, got);
        o_errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_translation want;
        t_translation got;
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    shadow_valid[s][w] = 1'b0;
                    shadow_entry[s][w] = '0;
                    shadow_rank[s][w]  = w;
                end
            end
            expected_translations.delete();
            o_errors = 0;
            o_fills  = 0;
            o_hits   = 0;
            o_misses = 0;
        end else begin
            // results leave before the new request enters
            if (i_out_valid && !i_out_stall) begin
                got.hit  = i_hit;
                got.phys = i_phys_page;
                if (expected_translations.size() == 0) begin
                    report_mismatch("result with no request outstanding", '0, got);
                end else begin
                    want = expected_translations[0];
                    expected_translations.delete(0);
                    if (got.hit !== want.hit)
                        report_mismatch("hit", want.hit, got.hit);
                    if (got.phys !== want.phys)
                        report_mismatch("phys_page", want.phys, got.phys);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = translate_request(i_cmd, i_space_id, i_virt_page,
                                         i_fill_phys_page);
                expected_translations = {expected_translations, want};
                if (i_cmd == satlb_pkg::CMD_FILL)
                    o_fills++;
                else if (want.hit)
                    o_hits++;
                else
                    o_misses++;
            end
        end
        o_outstanding = expected_translations.size();
    end

endmodule

// ----- test/set_assoc_tlb_lru_tb.sv -----
`timescale 1ns / 1ps

module set_assoc_tlb_lru_tb;

    localparam int unsigned SETS       = 32;
    localparam int unsigned WAYS       = 4;
    localparam int          NUM_RANDOM = 1600;
    localparam int          POOL_SIZE  = 40;
    localparam int          DRAIN      = 16;
    localparam int          LIMIT      = 200000;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          in_valid         = 1'b0;
    logic                          cmd              = satlb_pkg::CMD_PROBE;
    logic [satlb_pkg::SPACE_W-1:0] space_id         = '0;
    logic [satlb_pkg::PAGE_W-1:0]  virt_page        = '0;
    logic [satlb_pkg::PAGE_W-1:0]  fill_phys_page   = '0;
    logic                          out_stall        = 1'b0;
    logic                          in_stall;
    logic                          out_valid;
    logic                          hit;
    logic [satlb_pkg::PAGE_W-1:0]  phys_page;

    bit steady = 1'b0;  // no idling on either side while set
    int cycle_count = 0;
    int errors, outstanding, fills, hits, misses;

    // Hot keys, packed into a few sets so that evictions happen often
    logic [satlb_pkg::SPACE_W-1:0] pool_space [POOL_SIZE];
    logic [satlb_pkg::PAGE_W-1:0]  pool_page  [POOL_SIZE];

    always #2 i_clk = ~i_clk;

    set_assoc_tlb_lru #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_space_id       (space_id),
        .i_virt_page      (virt_page),
        .i_fill_phys_page (fill_phys_page),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_hit            (hit),
        .o_phys_page      (phys_page)
    );

    set_assoc_tlb_lru_chk #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_space_id       (space_id),
        .i_virt_page      (virt_page),
        .i_fill_phys_page (fill_phys_page),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_hit            (hit),
        .i_phys_page      (phys_page),
        .o_errors         (errors),
        .o_outstanding    (outstanding),
        .o_fills          (fills),
        .o_hits           (hits),
        .o_misses         (misses)
    );

    // Receiver back-pressure
    always @(negedge i_clk) begin
        out_stall <= i_rst_n && !steady && ($urandom_range(99) < 38);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [satlb_pkg::PAGE_W-1:0] rand_page();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[satlb_pkg::PAGE_W-1:0];
    endfunction

    // Hot key: random upper bits, set among the first eight
    function automatic logic [satlb_pkg::PAGE_W-1:0] hot_page();
        logic [satlb_pkg::PAGE_W-1:0] page;
        page      = rand_page();
        page[4:0] = 5'($urandom_range(7));
        return page;
    endfunction

    // Drive one request at the falling edge and hold it until taken
    task automatic send_request(
        input logic                          req_cmd,
        input logic [satlb_pkg::SPACE_W-1:0] req_space,
        input logic [satlb_pkg::PAGE_W-1:0]  req_page,
        input logic [satlb_pkg::PAGE_W-1:0]  req_phys
    );
        while (!steady && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid       <= 1'b1;
        cmd            <= req_cmd;
        space_id       <= req_space;
        virt_page      <= req_page;
        fill_phys_page <= req_phys;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [satlb_pkg::PAGE_W-1:0] ones;
        logic [satlb_pkg::PAGE_W-1:0] dup_page;
        int                           pick;
        int                           kind;
        ones     = '1;
        dup_page = {rand_page()} & ~52'h1F | 52'd9;

        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_space[k] = 16'($urandom_range(3));
            pool_page[k]  = hot_page();
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty buffer, extreme keys and payloads
        send_request(satlb_pkg::CMD_PROBE, 16'h0000, '0, '0);
        send_request(satlb_pkg::CMD_FILL, 16'hFFFF, ones, ones);
        send_request(satlb_pkg::CMD_PROBE, 16'hFFFF, ones, '0);
        send_request(satlb_pkg::CMD_PROBE, 16'hFFFE, ones, '0);
        send_request(satlb_pkg::CMD_FILL, 16'h0000, '0, '0);
        send_request(satlb_pkg::CMD_PROBE, 16'h0000, '0, ones);

        // Fill one set past its ways; a touched way survives the eviction
        for (int k = 1; k <= 4; k++)
            send_request(satlb_pkg::CMD_FILL, 16'h0007, 52'(k * 32 + 3), rand_page());
        send_request(satlb_pkg::CMD_PROBE, 16'h0007, 52'(1 * 32 + 3), '0);
        send_request(satlb_pkg::CMD_FILL, 16'h0007, 52'(5 * 32 + 3), rand_page());
        send_request(satlb_pkg::CMD_PROBE, 16'h0007, 52'(2 * 32 + 3), '0);
        send_request(satlb_pkg::CMD_PROBE, 16'h0007, 52'(5 * 32 + 3), '0);
        send_request(satlb_pkg::CMD_PROBE, 16'h0007, 52'(3 * 32 + 3), '0);

        // Duplicate fills: the lower way answers
        send_request(satlb_pkg::CMD_FILL, 16'h1234, dup_page, 52'hA_AAAA_AAAA_AAAA);
        send_request(satlb_pkg::CMD_FILL, 16'h1234, dup_page, 52'h5_5555_5555_5555);
        send_request(satlb_pkg::CMD_PROBE, 16'h1234, dup_page, ones);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // one stretch with no idling, one full drain
            steady = (n >= 700 && n < 1000);
            if (n == 400) begin
                in_valid <= 1'b0;
                wait (outstanding == 0);
                @(negedge i_clk);
            end
            if (n % 20 == 0) begin
                pick             = $urandom_range(POOL_SIZE - 1);
                pool_space[pick] = 16'($urandom_range(3));
                pool_page[pick]  = hot_page();
            end
            pick = $urandom_range(POOL_SIZE - 1);
            kind = $urandom_range(99);
            if (kind < 40)
                send_request(satlb_pkg::CMD_FILL, pool_space[pick], pool_page[pick],
                             rand_page());
            else if (kind < 85)
                send_request(satlb_pkg::CMD_PROBE, pool_space[pick], pool_page[pick],
                             rand_page());
            else if (kind < 90)
                send_request(satlb_pkg::CMD_PROBE, 16'($urandom), pool_page[pick],
                             rand_page());
            else
                send_request(1'($urandom), 16'($urandom), rand_page(), rand_page());
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN) @(posedge i_clk);

        $display("Covered %0d fills, %0d probe hits and %0d probe misses, with evictions,",
                 fills, hits, misses);
        $display("duplicate fills, space mismatches and stalls on both channels.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
